// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_ON(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/dfr_pkg.sv =====
`default_nettype none
package dfr_pkg;

  localparam int unsigned ALIAS_W     = 12;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned WORD_W      = 64;
  localparam logic [CNT_W-1:0]   FRAME_BYTES   = 4'd8;
  localparam logic [CNT_W-1:0]   REJECT_BYTES  = 4'd2;
  localparam logic [15:0]        REJECT_CODE   = 16'h1000;
  localparam logic [ALIAS_W-1:0] OWN_ALIAS_RST = 12'd1;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_FIRST  = 2'd1,
    KIND_MIDDLE = 2'd2,
    KIND_FINAL  = 2'd3
  } frame_kind_e;

  typedef enum logic [1:0] {
    REPLY_ACK    = 2'd0,
    REPLY_REJECT = 2'd1,
    REPLY_DATA   = 2'd2
  } reply_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_ACK,
    ST_READ,
    ST_WORD,
    ST_REJECT
  } state_e;

  // Bookkeeping update applied once per frame
  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIRST,
    OP_APPEND,
    OP_CLOSE,
    OP_SINGLE,
    OP_REJECT
  } dp_op_e;

  typedef struct packed {
    logic        capture;
    dp_op_e      op;
    logic        wr_step;
    logic        rd_init;
    logic        word_init;
    logic        rd_issue;
    logic        out_load;
    reply_kind_e out_sel;
  } dfr_cmd_t;

  typedef struct packed {
    logic        hit;
    frame_kind_e kind;
    logic        active;
    logic        holder_hit;
    logic        overflow;
    logic        wr_done;
    logic        issue_done;
    logic        all_read;
    logic        empty;
    logic        out_free;
  } dfr_status_t;

endpackage
`default_nettype wire

// ===== rtl/dfr_ctrl.sv =====
`default_nettype none
module dfr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_valid_i,
  output logic                      s_ready_o,
  input  wire dfr_pkg::dfr_status_t status_i,
  output dfr_pkg::dfr_cmd_t         cmd_o
);
  import dfr_pkg::*;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d           = state_q;
    emit_d            = emit_q;
    s_ready_o         = 1'b0;
    cmd_o.capture     = 1'b0;
    cmd_o.op          = OP_NONE;
    cmd_o.wr_step     = 1'b0;
    cmd_o.rd_init     = 1'b0;
    cmd_o.word_init   = 1'b0;
    cmd_o.rd_issue    = 1'b0;
    cmd_o.out_load    = 1'b0;
    cmd_o.out_sel     = REPLY_ACK;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_IDLE;
        emit_d  = 1'b0;
        if (status_i.hit) begin
          case (status_i.kind)
            KIND_SINGLE: begin
              cmd_o.op = OP_SINGLE;
              emit_d   = 1'b1;
              state_d  = ST_WRITE;
            end
            KIND_FIRST: begin
              cmd_o.op = OP_FIRST;
              state_d  = ST_WRITE;
            end
            KIND_MIDDLE: begin
              if (status_i.active && status_i.holder_hit) begin
                if (status_i.overflow) begin
                  cmd_o.op = OP_REJECT;
                  state_d  = ST_REJECT;
                end else begin
                  cmd_o.op = OP_APPEND;
                  state_d  = ST_WRITE;
                end
              end
            end
            KIND_FINAL: begin
              // stray final frame is a datagram of its own
              if (!status_i.active) begin
                cmd_o.op = OP_SINGLE;
                emit_d   = 1'b1;
                state_d  = ST_WRITE;
              end else if (status_i.holder_hit) begin
                if (status_i.overflow) begin
                  cmd_o.op = OP_REJECT;
                  state_d  = ST_REJECT;
                end else begin
                  cmd_o.op = OP_CLOSE;
                  emit_d   = 1'b1;
                  state_d  = ST_WRITE;
                end
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        if (status_i.wr_done) begin
          state_d = emit_q ? ST_ACK : ST_IDLE;
        end else begin
          cmd_o.wr_step = 1'b1;
        end
      end
      ST_ACK: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = REPLY_ACK;
          cmd_o.rd_init  = 1'b1;
          state_d        = status_i.empty ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.issue_done) begin
          state_d = ST_WORD;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end
      ST_WORD: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = REPLY_DATA;
          cmd_o.word_init = 1'b1;
          state_d         = status_i.all_read ? ST_IDLE : ST_READ;
        end
      end
      ST_REJECT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = REPLY_REJECT;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/dfr_datapath.sv =====
`default_nettype none
module dfr_datapath #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 72
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // captured frame fields
  input  wire dfr_pkg::frame_kind_e                   frame_kind_i,
  input  wire logic [dfr_pkg::ALIAS_W-1:0]            source_alias_i,
  input  wire logic [dfr_pkg::ALIAS_W-1:0]            dest_alias_i,
  input  wire logic [dfr_pkg::CNT_W-1:0]              byte_count_i,
  input  wire logic [dfr_pkg::WORD_W-1:0]             payload_i,
  // own alias register
  input  wire logic                                   cfg_we_i,
  input  wire logic [dfr_pkg::ALIAS_W-1:0]            cfg_alias_i,
  // result register
  output dfr_pkg::reply_kind_e                        reply_kind_o,
  output logic [dfr_pkg::ALIAS_W-1:0]                 peer_alias_o,
  output logic [dfr_pkg::WORD_W-1:0]                  data_word_o,
  output logic [dfr_pkg::CNT_W-1:0]                   valid_bytes_o,
  output logic                                        last_o,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  // controller link
  input  wire dfr_pkg::dfr_cmd_t                      cmd_i,
  output dfr_pkg::dfr_status_t                        status_o
);
  import dfr_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_DATAGRAM_BYTES);
  localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_DATAGRAM_BYTES);

  // frame register
  frame_kind_e          kind_q;
  logic [ALIAS_W-1:0]   src_q, dst_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [WORD_W-1:0]    payload_q;

  // datagram bookkeeping
  logic [ALIAS_W-1:0]   own_alias_q;
  logic                 assembling_q;
  logic [ALIAS_W-1:0]   holder_q;
  logic [LEN_W-1:0]     held_len_q;
  logic [LEN_W-1:0]     base_q;
  logic [CNT_W-1:0]     wr_idx_q;

  // readout
  logic [LEN_W-1:0]     rd_pos_q;
  logic [CNT_W-1:0]     wcnt_q;
  logic [2:0]           lane_q;
  logic                 rd_pend_q;
  logic [WORD_W-1:0]    word_q;
  logic [7:0]           rd_data_q;

  // result register
  reply_kind_e          out_kind_q;
  logic [ALIAS_W-1:0]   out_peer_q;
  logic [WORD_W-1:0]    out_word_q;
  logic [CNT_W-1:0]     out_nbytes_q;
  logic                 out_last_q;
  logic                 out_valid_q;

  logic [7:0]           store_q [MAX_DATAGRAM_BYTES];

  logic [LEN_W:0]       sum_len;
  logic [LEN_W-1:0]     new_len;
  logic [LEN_W-1:0]     wr_addr;
  logic [7:0]           wr_byte;
  logic                 out_free;

  assign sum_len  = {1'b0, held_len_q} + (LEN_W + 1)'(cnt_q);
  assign new_len  = sum_len[LEN_W-1:0];
  assign wr_addr  = base_q + LEN_W'(wr_idx_q);
  assign wr_byte  = payload_q[{~wr_idx_q[2:0], 3'b000} +: 8];
  assign out_free = !out_valid_q || out_ready_i;

  // Status to the controller
  always_comb begin
    status_o.hit        = (dst_q == own_alias_q);
    status_o.kind       = kind_q;
    status_o.active     = assembling_q;
    status_o.holder_hit = (holder_q == src_q);
    status_o.overflow   = (sum_len > MAX_LEN);
    status_o.wr_done    = (wr_idx_q == cnt_q);
    status_o.issue_done = (wcnt_q == FRAME_BYTES) || (rd_pos_q == held_len_q);
    status_o.all_read   = (rd_pos_q == held_len_q);
    status_o.empty      = (held_len_q == '0);
    status_o.out_free   = out_free;
  end

  // Frame capture, count clamped to eight
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q    <= frame_kind_i;
      src_q     <= source_alias_i;
      dst_q     <= dest_alias_i;
      cnt_q     <= (byte_count_i > FRAME_BYTES) ? FRAME_BYTES : byte_count_i;
      payload_q <= payload_i;
    end
  end

  // Own alias register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_alias_q <= OWN_ALIAS_RST;
    end else if (cfg_we_i) begin
      own_alias_q <= cfg_alias_i;
    end
  end

  // Datagram state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assembling_q <= 1'b0;
      holder_q     <= '0;
      held_len_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_FIRST: begin
          holder_q     <= src_q;
          assembling_q <= 1'b1;
          held_len_q   <= LEN_W'(cnt_q);
        end
        OP_APPEND: held_len_q <= new_len;
        OP_CLOSE: begin
          held_len_q   <= new_len;
          assembling_q <= 1'b0;
        end
        OP_SINGLE: begin
          held_len_q   <= LEN_W'(cnt_q);
          assembling_q <= 1'b0;
        end
        OP_REJECT: assembling_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // Write pointer: frame goes in at the end of the held bytes, or at zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.op != OP_NONE) begin
      wr_idx_q <= '0;
      base_q   <= (cmd_i.op == OP_APPEND || cmd_i.op == OP_CLOSE) ? held_len_q : '0;
    end else if (cmd_i.wr_step) begin
      wr_idx_q <= wr_idx_q + 1'b1;
    end
  end

  // Byte store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_step) begin
      store_q[wr_addr[ADDR_W-1:0]] <= wr_byte;
    end
    rd_data_q <= store_q[rd_pos_q[ADDR_W-1:0]];
  end

  // Readout: one byte per cycle while reads are issued, into its lane of the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_init) begin
      rd_pos_q <= '0;
    end else if (cmd_i.rd_issue) begin
      rd_pos_q <= rd_pos_q + 1'b1;
    end
    if (cmd_i.rd_init || cmd_i.word_init) begin
      wcnt_q <= '0;
      word_q <= '0;
    end else begin
      if (cmd_i.rd_issue) begin
        wcnt_q <= wcnt_q + 1'b1;
        lane_q <= wcnt_q[2:0];
      end
      if (rd_pend_q) begin
        word_q[{~lane_q, 3'b000} +: 8] <= rd_data_q;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_sel;
      out_peer_q <= src_q;
      case (cmd_i.out_sel)
        REPLY_ACK: begin
          out_word_q   <= '0;
          out_nbytes_q <= '0;
          out_last_q   <= (held_len_q == '0);
        end
        REPLY_REJECT: begin
          out_word_q   <= {REJECT_CODE, {(WORD_W - 16){1'b0}}};
          out_nbytes_q <= REJECT_BYTES;
          out_last_q   <= 1'b1;
        end
        default: begin
          out_word_q   <= word_q;
          out_nbytes_q <= wcnt_q;
          out_last_q   <= (rd_pos_q == held_len_q);
        end
      endcase
    end
  end

  assign reply_kind_o  = out_kind_q;
  assign peer_alias_o  = out_peer_q;
  assign data_word_o   = out_word_q;
  assign valid_bytes_o = out_nbytes_q;
  assign last_o        = out_last_q;
  assign out_valid_o   = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/datagram_frame_reassembler.sv =====
// Channel     Dir  Signals                              Content
// s_axis      in   tvalid tready tdata[95:0] tuser[1:0] decoded datagram frame
// m_axis      out  tvalid tready tdata[79:0] tuser[1:0] ack, reject or data word
//                  tlast                                last result of a frame
// cfg         in   cfg_valid_i cfg_ready_o cfg_data_i   own alias write
//
// One frame at a time: accept, decide, then write the payload bytes one by
// one into the byte store (single write port) and finish the write. A
// completed datagram adds an ack and a readout (a store read per byte, then
// a settle step and a word load per word); both wait while m_axis stalls.
// Reset clears the datagram state; the store holds no reset value. The
// result register lets a new frame in while the last result still waits.
`default_nettype none
module datagram_frame_reassembler #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 72
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // frame in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [11:0] source_alias, [23:12] dest_alias, [27:24] byte_count,
  // [91:28] payload, [95:92] zero
  input  wire logic [95:0] s_axis_tdata,
  // [1:0] frame_kind
  input  wire logic [1:0]  s_axis_tuser,
  // results out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [11:0] peer_alias, [75:12] data_word, [79:76] valid_bytes
  output logic [79:0]      m_axis_tdata,
  // [1:0] reply_kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  // own alias write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_data_i
);
  import dfr_pkg::*;

  dfr_cmd_t              cmd;
  dfr_status_t           status;
  reply_kind_e           reply_kind;
  logic [ALIAS_W-1:0]    peer_alias;
  logic [WORD_W-1:0]     data_word;
  logic [CNT_W-1:0]      valid_bytes;

  assign cfg_ready_o = 1'b1;

  dfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dfr_datapath #(
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_kind_i   (frame_kind_e'(s_axis_tuser)),
    .source_alias_i (s_axis_tdata[11:0]),
    .dest_alias_i   (s_axis_tdata[23:12]),
    .byte_count_i   (s_axis_tdata[27:24]),
    .payload_i      (s_axis_tdata[91:28]),
    .cfg_we_i       (cfg_valid_i),
    .cfg_alias_i    (cfg_data_i),
    .reply_kind_o   (reply_kind),
    .peer_alias_o   (peer_alias),
    .data_word_o    (data_word),
    .valid_bytes_o  (valid_bytes),
    .last_o         (m_axis_tlast),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .cmd_i          (cmd),
    .status_o       (status)
  );

  assign m_axis_tdata = {valid_bytes, data_word, peer_alias};
  assign m_axis_tuser = reply_kind;

endmodule
`default_nettype wire

// ===== rtl/dfr_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module dfr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import dfr_pkg::*;

  // a stalled result holds
  `ASSERT_DEF(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

  // only ack, reject and data codes appear
  `ASSERT_DEF(a_kind_known, m_axis_tvalid |-> m_axis_tuser != 2'd3, "unknown reply kind")

  // a reject closes the frame and carries the two-byte code
  `ASSERT_DEF(a_reject_form, m_axis_tvalid && m_axis_tuser == REPLY_REJECT |-> m_axis_tlast && m_axis_tdata[79:76] == REJECT_BYTES && m_axis_tdata[75:60] == REJECT_CODE, "bad reject result")

  // a data word holds one to eight bytes
  `ASSERT_DEF(a_word_bytes, m_axis_tvalid && m_axis_tuser == REPLY_DATA |-> m_axis_tdata[79:76] != 4'd0 && m_axis_tdata[79:76] <= FRAME_BYTES, "bad data word count")

  // one frame in flight: no accept right after an accept
  `ASSERT_DEF(a_one_frame, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "frame accepted back to back")

endmodule

bind datagram_frame_reassembler dfr_checker u_dfr_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import dfr_pkg::*;

  localparam int unsigned DGRAM_MAX     = 72;
  // cycles with no handshake at all before the run is declared hung
  localparam int unsigned IDLE_LIMIT    = 2000;
  // a first frame can keep the byte store busy after the last result is out
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef struct packed {
    frame_kind_e        kind;
    logic [ALIAS_W-1:0] src;
    logic [ALIAS_W-1:0] dst;
    logic [CNT_W-1:0]   count;
    logic [WORD_W-1:0]  payload;
  } frame_t;

  typedef struct packed {
    reply_kind_e        kind;
    logic [ALIAS_W-1:0] peer;
    logic [WORD_W-1:0]  word;
    logic [CNT_W-1:0]   nbytes;
    logic               last;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [11:0] cfg_data_i;

  // predicted block state
  logic [ALIAS_W-1:0] node_alias;
  logic               dgram_open;
  logic [ALIAS_W-1:0] dgram_owner;
  int unsigned        dgram_len;
  logic [7:0]         dgram_bytes [DGRAM_MAX];
  logic [7:0]         frame_octets [8];
  reply_t             expected_replies [$];
  reply_t             head_reply;

  // no idle cycles on either side while set
  bit          steady;
  int unsigned mismatches       = 0;
  int unsigned frames_sent      = 0;
  int unsigned addressed_frames = 0;
  int unsigned acks_seen        = 0;
  int unsigned words_seen       = 0;
  int unsigned rejects_seen     = 0;
  int unsigned quiet_cycles     = 0;

  datagram_frame_reassembler #(
    .MAX_DATAGRAM_BYTES(DGRAM_MAX)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Ack, then the datagram bytes in 8-byte words, first byte in the top bits
  task automatic queue_datagram(input logic [ALIAS_W-1:0] peer, input int unsigned len,
                                input bit from_store);
    reply_t      r;
    int unsigned pos;
    int unsigned n;
    logic [7:0]  octet;
    r.kind   = REPLY_ACK;
    r.peer   = peer;
    r.word   = '0;
    r.nbytes = '0;
    r.last   = (len == 0);
    expected_replies.push_back(r);
    pos = 0;
    while (pos < len) begin
      n = (len - pos > 8) ? 8 : len - pos;
      r.kind = REPLY_DATA;
      r.word = '0;
      for (int i = 0; i < 8; i++) begin
        octet = 8'h00;
        if (i < n) octet = from_store ? dgram_bytes[pos + i] : frame_octets[pos + i];
        r.word = {r.word[55:0], octet};
      end
      pos += n;
      r.nbytes = CNT_W'(n);
      r.last   = (pos >= len);
      expected_replies.push_back(r);
    end
  endtask

  // Adds the frame bytes to the open datagram; on overflow queues the reject
  function automatic bit append_octets(input logic [ALIAS_W-1:0] src, input int unsigned cnt);
    reply_t r;
    if (dgram_len + cnt > DGRAM_MAX) begin
      r.kind   = REPLY_REJECT;
      r.peer   = src;
      r.word   = {REJECT_CODE, 48'h0};
      r.nbytes = REJECT_BYTES;
      r.last   = 1'b1;
      expected_replies.push_back(r);
      dgram_open = 1'b0;
      return 1'b0;
    end
    for (int i = 0; i < cnt; i++) dgram_bytes[dgram_len + i] = frame_octets[i];
    dgram_len += cnt;
    return 1'b1;
  endfunction

  // Expected results of one accepted frame
  task automatic reassemble_frame(input frame_t f);
    int unsigned cnt;
    if (f.dst != node_alias) return;
    cnt = (f.count > FRAME_BYTES) ? FRAME_BYTES : f.count;
    for (int i = 0; i < 8; i++)
      frame_octets[i] = (i < cnt) ? f.payload[63 - 8*i -: 8] : 8'h00;
    case (f.kind)
      KIND_SINGLE: begin
        dgram_open = 1'b0;
        queue_datagram(f.src, cnt, 1'b0);
      end
      KIND_FIRST: begin
        dgram_open  = 1'b1;
        dgram_owner = f.src;
        for (int i = 0; i < cnt; i++) dgram_bytes[i] = frame_octets[i];
        dgram_len = cnt;
      end
      KIND_MIDDLE: begin
        if (dgram_open && dgram_owner == f.src) void'(append_octets(f.src, cnt));
      end
      default: begin
        // a final frame with nothing open stands alone
        if (!dgram_open) begin
          queue_datagram(f.src, cnt, 1'b0);
        end else if (dgram_owner == f.src) begin
          if (append_octets(f.src, cnt)) begin
            dgram_open = 1'b0;
            queue_datagram(f.src, dgram_len, 1'b1);
          end
        end
      end
    endcase
  endtask

  function automatic frame_t make_frame(input frame_kind_e k, input logic [ALIAS_W-1:0] src,
                                        input logic [ALIAS_W-1:0] dst,
                                        input logic [CNT_W-1:0] cnt,
                                        input logic [WORD_W-1:0] pl);
    frame_t f;
    f.kind    = k;
    f.src     = src;
    f.dst     = dst;
    f.count   = cnt;
    f.payload = pl;
    return f;
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    return ($urandom_range(4) == 0) ? CNT_W'($urandom_range(15)) : CNT_W'($urandom_range(8));
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // a few fixed aliases so that sources repeat, plus the full range
  function automatic logic [ALIAS_W-1:0] pick_source();
    case ($urandom_range(3))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  // One frame, after a random gap; tvalid stays high for a back-to-back frame
  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(3);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f.kind;
    s_axis_tdata  <= {4'h0, f.payload, f.count, f.dst, f.src};
    do @(posedge clk_i); while (!s_axis_tready);
    reassemble_frame(f);
    frames_sent++;
    if (f.dst == node_alias) addressed_frames++;
  endtask

  // Hold frames back until every predicted result is out and the block is quiet
  task automatic drain_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_own_alias(input logic [ALIAS_W-1:0] alias_val);
    drain_replies();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= alias_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_alias = alias_val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Every frame kind and the corner cases of sequencing, at the reset alias
  task automatic test_frame_kinds();
    // addressed elsewhere: ignored
    send_frame(make_frame(KIND_SINGLE, 12'h0AB, 12'hFFE, 4'd8, rand_word()));
    // empty single frame: ack only
    send_frame(make_frame(KIND_SINGLE, 12'h000, node_alias, 4'd0, '1));
    // count above eight clamps to eight
    send_frame(make_frame(KIND_SINGLE, 12'hFFF, node_alias, 4'hF, '1));
    // other sources cut in while a datagram is open
    send_frame(make_frame(KIND_FIRST,  12'h123, node_alias, 4'd8, rand_word()));
    send_frame(make_frame(KIND_MIDDLE, 12'h456, node_alias, 4'd8, rand_word()));
    send_frame(make_frame(KIND_FINAL,  12'h456, node_alias, 4'd8, rand_word()));
    send_frame(make_frame(KIND_MIDDLE, 12'h123, node_alias, 4'd5, rand_word()));
    send_frame(make_frame(KIND_FINAL,  12'h123, node_alias, 4'd3, rand_word()));
    // nothing open: middle dropped, final stands alone
    send_frame(make_frame(KIND_MIDDLE, 12'h321, node_alias, 4'd4, rand_word()));
    send_frame(make_frame(KIND_FINAL,  12'h321, node_alias, 4'd4, rand_word()));
    // single frame closes the open datagram
    send_frame(make_frame(KIND_FIRST,  12'h123, node_alias, 4'd6, rand_word()));
    send_frame(make_frame(KIND_SINGLE, 12'h456, node_alias, 4'd2, rand_word()));
    send_frame(make_frame(KIND_FINAL,  12'h123, node_alias, 4'd7, rand_word()));
    // second first frame restarts collection
    send_frame(make_frame(KIND_FIRST,  12'h123, node_alias, 4'd8, rand_word()));
    send_frame(make_frame(KIND_FIRST,  12'h789, node_alias, 4'd3, rand_word()));
    send_frame(make_frame(KIND_FINAL,  12'h789, node_alias, 4'd0, rand_word()));
  endtask

  // Fill the store to the last byte, then one byte more
  task automatic test_overflow();
    send_frame(make_frame(KIND_FIRST, 12'hABC, node_alias, 4'd8, rand_word()));
    repeat (8) send_frame(make_frame(KIND_MIDDLE, 12'hABC, node_alias, 4'd8, rand_word()));
    send_frame(make_frame(KIND_MIDDLE, 12'hABC, node_alias, 4'd1, rand_word()));
  endtask

  // Mostly complete datagrams with random content, some full or overflowing,
  // with stray and broken frames mixed in
  task automatic test_random_traffic(input logic [ALIAS_W-1:0] alias_val,
                                     input int unsigned n_items);
    int unsigned        start;
    int unsigned        pick;
    int unsigned        mids;
    logic [ALIAS_W-1:0] src;
    frame_kind_e        k;
    write_own_alias(alias_val);
    start = addressed_frames;
    while (addressed_frames - start < n_items) begin
      pick = $urandom_range(99);
      src  = pick_source();
      if ($urandom_range(11) == 0) steady = ~steady;
      if (pick < 55) begin
        mids = ($urandom_range(3) == 0) ? $urandom_range(9) : $urandom_range(3);
        send_frame(make_frame(KIND_FIRST, src, node_alias, rand_count(), rand_word()));
        repeat (mids) begin
          if ($urandom_range(5) == 0) begin
            k = $urandom_range(1) ? KIND_MIDDLE : KIND_FINAL;
            send_frame(make_frame(k, src ^ 12'($urandom_range(4095, 1)), node_alias,
                                  rand_count(), rand_word()));
          end
          send_frame(make_frame(KIND_MIDDLE, src, node_alias, rand_count(), rand_word()));
        end
        send_frame(make_frame(KIND_FINAL, src, node_alias, rand_count(), rand_word()));
      end else if (pick < 63) begin
        // exactly full: nine frames of eight bytes
        send_frame(make_frame(KIND_FIRST, src, node_alias, 4'($urandom_range(15, 8)),
                              rand_word()));
        repeat (7)
          send_frame(make_frame(KIND_MIDDLE, src, node_alias, 4'($urandom_range(15, 8)),
                                rand_word()));
        send_frame(make_frame(KIND_FINAL, src, node_alias, 4'($urandom_range(15, 8)),
                              rand_word()));
      end else if (pick < 70) begin
        // full store, then a frame that does not fit
        send_frame(make_frame(KIND_FIRST, src, node_alias, 4'd8, rand_word()));
        repeat (8) send_frame(make_frame(KIND_MIDDLE, src, node_alias, 4'd8, rand_word()));
        k = $urandom_range(1) ? KIND_MIDDLE : KIND_FINAL;
        send_frame(make_frame(k, src, node_alias, 4'($urandom_range(15, 1)), rand_word()));
      end else if (pick < 85) begin
        send_frame(make_frame(KIND_SINGLE, src, node_alias, rand_count(), rand_word()));
      end else begin
        // any kind, to us or to another node
        send_frame(make_frame(frame_kind_e'($urandom_range(3)), pick_source(),
                              $urandom_range(1) ? node_alias
                                                : node_alias ^ 12'($urandom_range(4095, 1)),
                              rand_count(), rand_word()));
      end
      if ($urandom_range(24) == 0) drain_replies();
    end
  endtask

  // Result sink with a random stall before each item
  initial begin : sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady ? 0 : $urandom_range(3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string what, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, what, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (m_axis_tuser == REPLY_ACK) acks_seen++;
      else if (m_axis_tuser == REPLY_REJECT) rejects_seen++;
      else words_seen++;
      if (expected_replies.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d data %h last %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        head_reply = expected_replies.pop_front();
        check_field("reply_kind",  head_reply.kind,   m_axis_tuser);
        check_field("peer_alias",  head_reply.peer,   m_axis_tdata[11:0]);
        check_field("data_word",   head_reply.word,   m_axis_tdata[75:12]);
        check_field("valid_bytes", head_reply.nbytes, m_axis_tdata[79:76]);
        check_field("last",        head_reply.last,   m_axis_tlast);
      end
    end
  end

  // Hang detection
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == IDLE_LIMIT) begin
        $display("%0t no handshake for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, expected_replies.size());
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    steady        = 1'b0;
    node_alias    = OWN_ALIAS_RST;
    dgram_open    = 1'b0;
    dgram_owner   = '0;
    dgram_len     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_frame_kinds();
    test_overflow();
    test_random_traffic(12'hFFF, 130);
    test_random_traffic(12'($urandom_range(4094, 2)), 130);
    test_random_traffic(12'h001, 130);

    drain_replies();
    $display("Sent %0d frames (%0d addressed to the node) over four alias settings;",
             frames_sent, addressed_frames);
    $display("checked %0d acks, %0d data words and %0d overflow rejects.",
             acks_seen, words_seen, rejects_seen);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
